@@ hw/rtl/tsb_pkg.sv @@
// Shared types, constants and helpers for the time-sorted sample buffer.
// No dependencies; imported by every module of the block except tsb_ram.
`default_nettype none

package tsb_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int VAL_W    = 10;
  localparam int TIME_W   = 32;
  localparam int HOURS_W  = 8;
  localparam int MAXC_W   = 7;
  localparam int ECNT_W   = 7;
  localparam int CMP_W    = MAXC_W + 1;
  localparam int SPAN_W   = HOURS_W + 12;
  localparam int ENTRY_W  = TIME_W + VAL_W;

  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IGNORED   = 3'd0,
    ST_STORED    = 3'd1,
    ST_UPDATED   = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_DISCARDED = 3'd4,
    ST_READ      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [VAL_W-1:0]    value;
    logic [TIME_W-1:0]   tstamp;
    logic [HOURS_W-1:0]  hours;
    logic [MAXC_W-1:0]   maxc;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [VAL_W-1:0]    value;
    logic [TIME_W-1:0]   tstamp;
    logic                item_valid;
    logic                last;
    logic [ECNT_W-1:0]   count;
  } res_t;

  // logical slot (0 = oldest) to physical RAM address in the ring
  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] lidx);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(lidx);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] next_head(input logic [IDX_W-1:0] head);
    logic [IDX_W-1:0] nh;
    if (head == IDX_W'(CAPACITY - 1)) begin
      nh = '0;
    end else begin
      nh = head + 1'b1;
    end
    return nh;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tsb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first on a same-address collision. No dependencies.
`default_nettype none

module tsb_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/tsb_out_stage.sv @@
// Result register between the controller and the output stream.
// Depends on tsb_pkg for the result struct.
`default_nettype none

module tsb_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  input  wire tsb_pkg::res_t res,
  output logic               res_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tsb_pkg::res_t      out_res
);
  import tsb_pkg::*;

  logic valid_r;
  res_t res_r;

  // free when empty or being drained this cycle
  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tsb_ctl.sv @@
// Sequencer for the sample buffer: search, shift, insert and window readout
// over the ring-organized sample RAM. Depends on tsb_pkg and drives tsb_ram.
`default_nettype none

module tsb_ctl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire tsb_pkg::req_t                     req,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output tsb_pkg::res_t                          res,
  output logic                                   ram_we,
  output logic [tsb_pkg::IDX_W-1:0]              ram_waddr,
  output logic [tsb_pkg::ENTRY_W-1:0]            ram_wdata,
  output logic [tsb_pkg::IDX_W-1:0]              ram_raddr,
  input  wire logic [tsb_pkg::ENTRY_W-1:0]       ram_rdata
);
  import tsb_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SRCH  = 8'b0000_0010,
    S_SHIFT = 8'b0000_0100,
    S_PUT   = 8'b0000_1000,
    S_NOW   = 8'b0001_0000,
    S_RREQ  = 8'b0010_0000,
    S_RWAIT = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [TIME_W-1:0]  tim_r, tim_nxt;
  logic [SPAN_W-1:0]  span_r, span_nxt;
  logic [TIME_W-1:0]  cutoff_r, cutoff_nxt;
  logic [MAXC_W-1:0]  maxc_r, maxc_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   got_r, got_nxt;
  status_t            status_r, status_nxt;

  logic               accept;
  logic               full;
  logic [TIME_W-1:0]  rd_time;
  logic [VAL_W-1:0]   rd_val;
  logic               do_put;
  logic [CNT_W-1:0]   put_pos;
  logic [VAL_W-1:0]   put_val;
  logic [TIME_W-1:0]  put_time;
  logic [CNT_W-1:0]   found_pos;
  logic               rd_last;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign rd_time  = ram_rdata[ENTRY_W-1:VAL_W];
  assign rd_val   = ram_rdata[VAL_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    val_nxt    = val_r;
    tim_nxt    = tim_r;
    span_nxt   = span_r;
    cutoff_nxt = cutoff_r;
    maxc_nxt   = maxc_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    got_nxt    = got_r;
    status_nxt = status_r;

    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;

    res_valid  = 1'b0;
    res        = '0;

    do_put     = 1'b0;
    put_pos    = pos_r;
    put_val    = val_r;
    put_time   = tim_r;
    found_pos  = '0;
    rd_last    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt  = req.value;
          tim_nxt  = req.tstamp;
          maxc_nxt = req.maxc;
          span_nxt = SPAN_W'(req.hours) * SPAN_W'(SEC_PER_HOUR);
          case (req.op)
            OP_INSERT: begin
              if (req.value == '0 || req.tstamp == '0) begin
                status_nxt = ST_IGNORED;
                state_nxt  = S_DONE;
              end else if (count_r == '0) begin
                do_put   = 1'b1;
                put_pos  = '0;
                put_val  = req.value;
                put_time = req.tstamp;
              end else begin
                // search from the newest entry down
                idx_nxt   = count_r - 1'b1;
                ram_raddr = phys_addr(head_r, count_r - 1'b1);
                state_nxt = S_SRCH;
              end
            end
            OP_READ: begin
              if (count_r == '0 || req.maxc == '0) begin
                status_nxt = ST_READ;
                state_nxt  = S_DONE;
              end else begin
                ram_raddr = phys_addr(head_r, count_r - 1'b1);
                state_nxt = S_NOW;
              end
            end
            OP_CLEAR: begin
              count_nxt  = '0;
              status_nxt = ST_CLEARED;
              state_nxt  = S_DONE;
            end
            default: begin
              status_nxt = ST_IGNORED;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_SRCH: begin
        if (rd_time == tim_r) begin
          ram_we     = 1'b1;
          ram_waddr  = phys_addr(head_r, idx_r);
          ram_wdata  = {tim_r, val_r};
          status_nxt = ST_UPDATED;
          state_nxt  = S_DONE;
        end else if (rd_time < tim_r || idx_r == '0) begin
          found_pos = (rd_time < tim_r) ? idx_r + 1'b1 : '0;
          if (found_pos == count_r) begin
            do_put  = 1'b1;
            put_pos = found_pos;
          end else if (full && found_pos == '0) begin
            status_nxt = ST_DISCARDED;
            state_nxt  = S_DONE;
          end else begin
            // move entries found_pos..count-1 up one slot, newest first
            pos_nxt   = found_pos;
            idx_nxt   = count_r - 1'b1;
            ram_raddr = phys_addr(head_r, count_r - 1'b1);
            state_nxt = S_SHIFT;
          end
        end else begin
          idx_nxt   = idx_r - 1'b1;
          ram_raddr = phys_addr(head_r, idx_r - 1'b1);
        end
      end

      S_SHIFT: begin
        // when full, the top write lands on the oldest slot, which is dropped
        ram_we    = 1'b1;
        ram_waddr = phys_addr(head_r, idx_r + 1'b1);
        ram_wdata = ram_rdata;
        if (idx_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          ram_raddr = phys_addr(head_r, idx_r - 1'b1);
        end
      end

      S_PUT: begin
        do_put  = 1'b1;
        put_pos = pos_r;
      end

      S_NOW: begin
        cutoff_nxt = (rd_time > TIME_W'(span_r)) ? rd_time - TIME_W'(span_r) : '0;
        idx_nxt    = '0;
        got_nxt    = '0;
        state_nxt  = S_RREQ;
      end

      S_RREQ: begin
        // issue only with the result register free, so S_RWAIT can always load
        if (res_ready) begin
          ram_raddr = phys_addr(head_r, idx_r);
          state_nxt = S_RWAIT;
        end
      end

      S_RWAIT: begin
        if (rd_time >= cutoff_r) begin
          rd_last = (idx_r == count_r - 1'b1) ||
                    ((CMP_W'(got_r) + 1'b1) == CMP_W'(maxc_r));
          res_valid      = 1'b1;
          res.status     = ST_READ;
          res.value      = rd_val;
          res.tstamp     = rd_time;
          res.item_valid = 1'b1;
          res.last       = rd_last;
          res.count      = ECNT_W'(count_r);
          got_nxt        = got_r + 1'b1;
          if (rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RREQ;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RREQ;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          res_valid  = 1'b1;
          res.status = status_r;
          res.last   = 1'b1;
          res.count  = ECNT_W'(count_r);
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // place the new sample; a full ring advances its head past the oldest
    if (do_put) begin
      ram_we    = 1'b1;
      ram_waddr = phys_addr(head_r, put_pos);
      ram_wdata = {put_time, put_val};
      if (full) begin
        head_nxt   = next_head(head_r);
        status_nxt = ST_DROPPED;
      end else begin
        count_nxt  = count_r + 1'b1;
        status_nxt = ST_STORED;
      end
      state_nxt = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    tim_r    <= tim_nxt;
    span_r   <= span_nxt;
    cutoff_r <= cutoff_nxt;
    maxc_r   <= maxc_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    got_r    <= got_nxt;
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/time_sorted_sample_buffer_top.sv @@
// Time-sorted sample buffer top; uses tsb_pkg, tsb_ram, tsb_ctl and tsb_out_stage.
// Clear, unknown op, ignored insert, insert into empty and empty read need no RAM walk;
// other inserts scan entries from the newest down, then on a shift move entries up a slot,
// one entry at a time over the single RAM port pair. Read walks entries from the oldest,
// one result per entry in the window up to max_count. One item in flight; next transfer in
// taken at idle. Reset: sync, active low; empties store, RAM not cleared.
`default_nettype none

module time_sorted_sample_buffer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [9:0] glucose_value, [41:10] sample_time, [49:42] window_hours,
  // [56:50] max_count, [63:57] zero
  input  wire logic [63:0] in_tdata,
  // [1:0] operation
  input  wire logic [1:0]  in_tuser,

  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [9:0] out_value, [41:10] out_time, [48:42] entry_count, [55:49] zero
  output logic [55:0]      out_tdata,
  // [2:0] status, [3] item_valid
  output logic [3:0]       out_tuser,
  // last_item
  output logic             out_tlast
);
  import tsb_pkg::*;

  req_t               req;
  res_t               res;
  res_t               out_res;
  logic               res_valid;
  logic               res_ready;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // unpack the input transfer
  assign req.op     = op_t'(in_tuser);
  assign req.value  = in_tdata[9:0];
  assign req.tstamp = in_tdata[41:10];
  assign req.hours  = in_tdata[49:42];
  assign req.maxc   = in_tdata[56:50];

  // samples live in one ring-addressed RAM: {time, value} per entry
  tsb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: search, shift, insert, window walk
  tsb_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output register decouples the result transfer from the sequencer
  tsb_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {7'b0, out_res.count, out_res.tstamp, out_res.value};
  assign out_tuser = {out_res.item_valid, out_res.status};
  assign out_tlast = out_res.last;

endmodule

`default_nettype wire
